// ----- rtl/roc_auc_rank_sum_assert.svh -----
// Assertion macros used by the top-level RTL
`ifndef ROC_AUC_RANK_SUM_ASSERT_SVH
`define ROC_AUC_RANK_SUM_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RARS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rank sum assertion failed");

// antecedent implies consequent in the next cycle
`define RARS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rank sum assertion failed");

`endif

// ----- rtl/rars_pkg.sv -----
package rars_pkg;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_LABEL = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_OVERFLOW  = 2'd3;

	localparam logic [1:0] LAB_NEG = 2'd0;
	localparam logic [1:0] LAB_POS = 2'd1;

	// quotient bits of the AUC divide
	localparam int QBITS = 17;
	localparam logic [16:0] AUC_ONE = 17'd65536;

	typedef struct packed {
		logic signed [31:0] sample_score;
		logic [1:0]         label_code;
		logic               last_sample;
	} sample_t;

	typedef struct packed {
		logic [16:0] auc_value;
		logic [1:0]  status;
		logic [10:0] positive_count;
		logic [10:0] negative_count;
	} result_t;

	typedef struct packed {
		logic load;
		logic rd_i;
		logic lat_i;
		logic rd_j;
		logic add_rank;
		logic next_i;
		logic mul;
		logic div_init;
		logic div_step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic last_j;
		logic last_i;
		logic lab_pos;
		logic err;
		logic div_last;
	} stat_t;

endpackage

// ----- rtl/rars_ctrl.sv -----
module rars_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_sample,
	input  rars_pkg::stat_t   stat,
	output rars_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic [11:0] {
		S_LOAD  = 12'b000000000001,
		S_CHK   = 12'b000000000010,
		S_RDI   = 12'b000000000100,
		S_LATI  = 12'b000000001000,
		S_SCAN  = 12'b000000010000,
		S_DRAIN = 12'b000000100000,
		S_ADDI  = 12'b000001000000,
		S_NEXTI = 12'b000010000000,
		S_MUL   = 12'b000100000000,
		S_PREP  = 12'b001000000000,
		S_DIV   = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_LOAD: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_sample) state_d = S_CHK;
				end
			end
			S_CHK:   state_d = stat.err ? S_DONE : S_RDI;
			S_RDI: begin
				cmd.rd_i = 1'b1;
				state_d = S_LATI;
			end
			S_LATI: begin
				cmd.lat_i = 1'b1;
				state_d = stat.lab_pos ? S_SCAN : S_NEXTI;
			end
			S_SCAN: begin
				cmd.rd_j = 1'b1;
				if (stat.last_j) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_ADDI;
			S_ADDI: begin
				cmd.add_rank = 1'b1;
				state_d = S_NEXTI;
			end
			S_NEXTI: begin
				cmd.next_i = 1'b1;
				state_d = stat.last_i ? S_MUL : S_RDI;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_PREP;
			end
			S_PREP: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = S_DONE;
			end
			S_DONE: begin
				cmd.fin = 1'b1;
				state_d = S_LOAD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	assign busy = (state_q != S_LOAD);
	assign done = (state_q == S_DONE);

endmodule

// ----- rtl/rars_dp.sv -----
module rars_dp #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rars_pkg::sample_t sample,
	input  rars_pkg::cmd_t    cmd,
	output rars_pkg::stat_t   stat,
	output rars_pkg::result_t result
);

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = 2 * CW + 1;
	localparam int RW = SW + rars_pkg::QBITS;

	logic [32:0] mem [MAX_SAMPLES];
	logic [32:0] mem_q;

	logic [CW-1:0] cnt_q, pcnt_q, ncnt_q;
	logic bad_q, ovf_q;
	logic [CW-1:0] i_q, j_q, less_q, eq_q, nm1;
	logic signed [31:0] key_i_q;
	logic vld_s1;
	logic [SW-1:0] sum_q;
	logic [2*CW-1:0] pn_q;
	logic [SW-1:0] pp_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] vdiv_q;
	logic [4:0] k_q;
	logic [16:0] quo_q;
	logic full, valid_lab;
	logic [AW-1:0] rd_addr;
	logic [RW-1:0] vsh;
	logic [1:0] st_code;
	logic [CW+10:0] pext, next;

	assign full = (cnt_q == CW'(MAX_SAMPLES));
	assign valid_lab = (sample.label_code == rars_pkg::LAB_NEG) ||
		(sample.label_code == rars_pkg::LAB_POS);
	assign nm1 = cnt_q - CW'(1);
	assign rd_addr = cmd.rd_i ? i_q[AW-1:0] : j_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load && valid_lab && !full)
			mem[cnt_q[AW-1:0]] <= {sample.label_code[0], sample.sample_score};
		if (cmd.rd_i || cmd.rd_j)
			mem_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pcnt_q <= '0;
			ncnt_q <= '0;
			bad_q <= 1'b0;
			ovf_q <= 1'b0;
			sum_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_j;
			if (cmd.load) begin
				if (!valid_lab) bad_q <= 1'b1;
				else if (full) ovf_q <= 1'b1;
				else begin
					cnt_q <= cnt_q + CW'(1);
					if (sample.label_code[0]) pcnt_q <= pcnt_q + CW'(1);
					else ncnt_q <= ncnt_q + CW'(1);
				end
			end
			if (cmd.add_rank)
				sum_q <= sum_q + SW'({less_q, 1'b0}) + SW'(eq_q) + SW'(1);
			if (cmd.fin) begin
				cnt_q <= '0;
				pcnt_q <= '0;
				ncnt_q <= '0;
				bad_q <= 1'b0;
				ovf_q <= 1'b0;
				sum_q <= '0;
			end
		end
	end

	// rank scan: for positive i, count keys below and equal to key i
	always_ff @(posedge clk) begin
		if (cmd.lat_i) begin
			key_i_q <= mem_q[31:0];
			less_q <= '0;
			eq_q <= '0;
			j_q <= '0;
		end
		if (cmd.rd_j) j_q <= j_q + CW'(1);
		if (vld_s1) begin
			if ($signed(mem_q[31:0]) < key_i_q) less_q <= less_q + CW'(1);
			else if ($signed(mem_q[31:0]) == key_i_q) eq_q <= eq_q + CW'(1);
		end
		if (cmd.mul) begin
			pn_q <= (2*CW)'(pcnt_q) * (2*CW)'(ncnt_q);
			pp_q <= SW'(pcnt_q) * (SW'(pcnt_q) + SW'(1));
		end
		if (cmd.div_init) begin
			rem_q <= RW'({(sum_q - pp_q), 16'b0}) + RW'(pn_q);
			vdiv_q <= RW'({pn_q, 1'b0});
			k_q <= 5'(rars_pkg::QBITS - 1);
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_q >= vsh) begin
				rem_q <= rem_q - vsh;
				quo_q[k_q] <= 1'b1;
			end
			k_q <= k_q - 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) i_q <= '0;
		else if (cmd.fin) i_q <= '0;
		else if (cmd.next_i) i_q <= i_q + CW'(1);
	end

	assign vsh = vdiv_q << k_q;

	always_comb begin
		if (bad_q) st_code = rars_pkg::ST_BAD_LABEL;
		else if (ovf_q) st_code = rars_pkg::ST_OVERFLOW;
		else if (pcnt_q == '0 || ncnt_q == '0) st_code = rars_pkg::ST_EMPTY;
		else st_code = rars_pkg::ST_OK;
	end

	assign pext = {11'b0, pcnt_q};
	assign next = {11'b0, ncnt_q};

	assign stat.last_j   = (j_q == nm1);
	assign stat.last_i   = (i_q == nm1);
	assign stat.lab_pos  = mem_q[32];
	assign stat.err      = (st_code != rars_pkg::ST_OK);
	assign stat.div_last = (k_q == 5'd0);

	always_comb begin
		result.status = st_code;
		result.positive_count = pext[10:0];
		result.negative_count = next[10:0];
		if (st_code != rars_pkg::ST_OK) result.auc_value = '0;
		else if (quo_q > rars_pkg::AUC_ONE) result.auc_value = rars_pkg::AUC_ONE;
		else result.auc_value = quo_q;
	end

endmodule

// ----- rtl/roc_auc_rank_sum.sv -----
// channel   ports                 handshake
// sample    sample (sample_t)     taken when start && !busy
// result    result (result_t)     valid for one cycle while done is high
//
// Samples load one per cycle into a single-port store; busy stays low while loading.
// After the last sample: a check state, then per stored sample a read and a latch state,
// for a positive a scan of the whole store (one store read per cycle), a drain and a rank
// add, then a next state; then multiply, divide setup and divide, and done.
// Sets with an error status skip the scan: the check state goes straight to done.
// Reset clears counts, flags, the rank sum, the read index and the state; the store needs no clear.
// The receiver cannot stall; done lasts one cycle.
`include "roc_auc_rank_sum_assert.svh"

module roc_auc_rank_sum #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rars_pkg::sample_t sample,
	output logic              busy,
	output logic              done,
	output rars_pkg::result_t result
);

	rars_pkg::cmd_t  cmd;
	rars_pkg::stat_t stat;

	rars_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_sample (sample.last_sample),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done)
	);

	rars_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	`RARS_ASSERT_NEXT(a_done_frees, done, !busy && !done)
	`RARS_ASSERT_IMPL(a_done_busy, done, busy)
	`RARS_ASSERT_IMPL(a_err_zero, done && result.status != rars_pkg::ST_OK, result.auc_value == '0)
	`RARS_ASSERT_IMPL(a_auc_range, done, result.auc_value <= rars_pkg::AUC_ONE)

endmodule

// ----- test/tb_roc_auc_rank_sum.sv -----
`timescale 1ns / 1ps

module tb_roc_auc_rank_sum;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	rars_pkg::sample_t sample = '0;
	logic              busy;
	logic              done;
	rars_pkg::result_t result;

	roc_auc_rank_sum dut (
		.clk(clk), .arst_n(arst_n), .start(start), .sample(sample),
		.busy(busy), .done(done), .result(result)
	);

	localparam int STORE_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 3000000;

	always #5 clk = ~clk;

	rars_pkg::sample_t  pending_samples[$];
	rars_pkg::result_t  auc_expected[$];
	logic signed [31:0] set_scores[$];
	logic               set_labels[$];
	logic               saw_bad_label = 1'b0;
	logic               saw_overflow = 1'b0;
	int                 total_items = 0;
	int                 accepted = 0;
	int                 errors = 0;
	int                 cycles = 0;

	// mirror of the block: store a sample, close the set on the last one
	task automatic absorb_sample(input rars_pkg::sample_t s);
		rars_pkg::result_t r;
		longint unsigned   pos, neg, twice_rank, less, eq, pn, num, auc;
		if (s.label_code != rars_pkg::LAB_NEG && s.label_code != rars_pkg::LAB_POS) begin
			saw_bad_label = 1'b1;
		end else if (set_scores.size() >= STORE_DEPTH) begin
			saw_overflow = 1'b1;
		end else begin
			set_scores.insert(set_scores.size(), s.sample_score);
			set_labels.insert(set_labels.size(), s.label_code == rars_pkg::LAB_POS);
		end
		if (!s.last_sample) return;
		pos = 0; neg = 0; twice_rank = 0; auc = 0;
		foreach (set_scores[i]) begin
			if (set_labels[i]) begin
				pos++;
				less = 0; eq = 0;
				foreach (set_scores[j]) begin
					if (set_scores[j] < set_scores[i]) less++;
					else if (set_scores[j] == set_scores[i]) eq++;
				end
				// tie group covers ranks less+1 .. less+eq
				twice_rank += 2 * less + eq + 1;
			end else begin
				neg++;
			end
		end
		if (saw_bad_label) r.status = rars_pkg::ST_BAD_LABEL;
		else if (saw_overflow) r.status = rars_pkg::ST_OVERFLOW;
		else if (pos == 0 || neg == 0) r.status = rars_pkg::ST_EMPTY;
		else begin
			r.status = rars_pkg::ST_OK;
			pn = pos * neg;
			num = twice_rank - pos * (pos + 1);
			auc = (num * 65536 + pn) / (2 * pn);
			if (auc > 65536) auc = 65536;
		end
		r.auc_value = auc[16:0];
		r.positive_count = pos[10:0];
		r.negative_count = neg[10:0];
		auc_expected.insert(auc_expected.size(), r);
		set_scores.delete();
		set_labels.delete();
		saw_bad_label = 1'b0;
		saw_overflow = 1'b0;
	endtask

	function automatic logic signed [31:0] pick_score();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 8)) - 4;
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 200)) * 1000;
		endcase
	endfunction

	task automatic queue_sample(input logic signed [31:0] sc, input logic [1:0] lab,
			input logic last);
		rars_pkg::sample_t s;
		s.sample_score = sc;
		s.label_code = lab;
		s.last_sample = last;
		pending_samples.insert(pending_samples.size(), s);
		total_items++;
	endtask

	// sender: hold a request until taken, then maybe idle
	always @(posedge clk or negedge arst_n) begin
		int  phase;
		int  idle_pct;
		logic taken;
		if (!arst_n) begin
			start <= 1'b0;
			sample <= '0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				absorb_sample(sample);
				accepted++;
			end
			phase = total_items ? (accepted * 4) / total_items : 0;
			idle_pct = (phase == 1) ? 73 : (phase == 3) ? 30 : 0;
			if (start && !taken) begin
				// still waiting for the block
			end else if (pending_samples.size() != 0 &&
					$urandom_range(0, 99) >= idle_pct) begin
				start <= 1'b1;
				sample <= pending_samples.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		rars_pkg::result_t want;
		if (arst_n && done) begin
			if (auc_expected.size() == 0) begin
				$display("%0t: unexpected result auc=%0d status=%0d pos=%0d neg=%0d",
					$time, result.auc_value, result.status,
					result.positive_count, result.negative_count);
				errors++;
			end else begin
				want = auc_expected.pop_front();
				if (result.auc_value !== want.auc_value) begin
					$display("%0t: auc_value expected %0d got %0d",
						$time, want.auc_value, result.auc_value);
					errors++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d got %0d",
						$time, want.status, result.status);
					errors++;
				end
				if (result.positive_count !== want.positive_count) begin
					$display("%0t: positive_count expected %0d got %0d",
						$time, want.positive_count, result.positive_count);
					errors++;
				end
				if (result.negative_count !== want.negative_count) begin
					$display("%0t: negative_count expected %0d got %0d",
						$time, want.negative_count, result.negative_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int n;
		logic [1:0] lab;
		// extremes, mixed labels
		queue_sample(32'sh80000000, rars_pkg::LAB_NEG, 1'b0);
		queue_sample(32'sh7fffffff, rars_pkg::LAB_POS, 1'b1);
		// reversed order gives zero
		queue_sample(32'sh80000000, rars_pkg::LAB_POS, 1'b0);
		queue_sample(32'sh7fffffff, rars_pkg::LAB_NEG, 1'b1);
		// all tied
		queue_sample(32'sd5, rars_pkg::LAB_POS, 1'b0);
		queue_sample(32'sd5, rars_pkg::LAB_NEG, 1'b0);
		queue_sample(32'sd5, rars_pkg::LAB_POS, 1'b1);
		// invalid labels, one of them closing the set
		queue_sample(-32'sd1, rars_pkg::LAB_POS, 1'b0);
		queue_sample(32'sd3, 2'd2, 1'b0);
		queue_sample(32'sd4, rars_pkg::LAB_NEG, 1'b1);
		queue_sample(32'sd1, rars_pkg::LAB_NEG, 1'b0);
		queue_sample(32'sd2, rars_pkg::LAB_POS, 1'b0);
		queue_sample(32'sd9, 2'd3, 1'b1);
		// empty class, lone sample, lone invalid
		queue_sample(32'sd7, rars_pkg::LAB_POS, 1'b0);
		queue_sample(32'sd8, rars_pkg::LAB_POS, 1'b1);
		queue_sample(32'sd0, rars_pkg::LAB_NEG, 1'b1);
		queue_sample(32'sd0, 2'd3, 1'b1);
		// partial ties
		queue_sample(32'sd10, rars_pkg::LAB_NEG, 1'b0);
		queue_sample(32'sd10, rars_pkg::LAB_POS, 1'b0);
		queue_sample(-32'sd10, rars_pkg::LAB_NEG, 1'b0);
		queue_sample(32'sd20, rars_pkg::LAB_POS, 1'b1);
		// store full: a few samples past capacity
		for (int i = 0; i < STORE_DEPTH + 4; i++)
			queue_sample(pick_score(), i[0] ? rars_pkg::LAB_POS : rars_pkg::LAB_NEG,
				i == STORE_DEPTH + 3);
		while (total_items < 1950) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				lab = ($urandom_range(0, 39) == 0) ? 2'($urandom_range(2, 3)) :
					2'($urandom_range(0, 1));
				queue_sample(pick_score(), lab, i == n - 1);
			end
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_samples.size() == 0 && accepted == total_items &&
			auc_expected.size() == 0);
		repeat (3000) @(posedge clk);
		if (errors == 0 && auc_expected.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/rars_pkg.sv
rtl/rars_ctrl.sv
rtl/rars_dp.sv
rtl/roc_auc_rank_sum.sv
test/tb_roc_auc_rank_sum.sv
